// ===== design/dmwtc_pkg.sv =====
`default_nettype none

package dmwtc_pkg;

  // Access selector carried in the mode field of an input word.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FILL  = 2'd2;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OFFSET_W = 2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clear_en;  // write an invalid entry at the sweep index, advance the sweep
    logic accept;    // latch the input word and read its line
    logic commit;    // resolve the access, update state, load the output register
  } dmwtc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;  // sweep index is at the last line
    logic out_free;    // output register is empty or being taken this cycle
  } dmwtc_status_t;

endpackage

`default_nettype wire

// ===== design/dmwtc_ctrl.sv =====
`default_nettype none

module dmwtc_ctrl import dmwtc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dmwtc_status_t status_i,
  output dmwtc_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // Hold the looked-up line until the output register can take the result.
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/dmwtc_dpath.sv =====
`default_nettype none

module dmwtc_dpath import dmwtc_pkg::*; #(
  parameter int unsigned INDEX_BITS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dmwtc_cmd_t  cmd_i,
  output dmwtc_status_t    status_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [31:0] fill_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             read_valid_o,
  output logic [31:0]      read_data_o,
  output logic             hit_o,
  output logic             fill_request_o,
  output logic [31:0]      request_address_o,
  output logic             memory_write_o,
  output logic [31:0]      memory_write_data_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o,
  output logic             protocol_error_o
);

  localparam int unsigned LINES   = 2 ** INDEX_BITS;
  localparam int unsigned TAG_W   = WORD_W - INDEX_BITS - OFFSET_W;
  localparam int unsigned ENTRY_W = 1 + TAG_W + WORD_W;
  localparam int unsigned TAG_LSB = INDEX_BITS + OFFSET_W;

  // Line entry layout: {valid, tag, word}.
  logic [ENTRY_W-1:0] lines_mem [LINES];
  logic [ENTRY_W-1:0] rd_entry_q;

  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_idx;
  logic [ENTRY_W-1:0]    wr_entry;

  logic [INDEX_BITS-1:0] clr_idx_q;

  logic [1:0]  mode_q;
  logic [31:0] addr_q, wdata_q, fdata_q;

  logic        pending_q, pending_d;
  logic [31:0] pend_addr_q, pend_addr_d;
  logic [31:0] hit_cnt_q, hit_cnt_d;
  logic [31:0] miss_cnt_q, miss_cnt_d;

  logic        out_valid_q;
  logic        rvalid_d, hit_d, freq_d, mwrite_d, perr_d;
  logic [31:0] rdata_d, raddr_d, mdata_d;
  logic        rvalid_q, hit_q, freq_q, mwrite_q, perr_q;
  logic [31:0] rdata_q, raddr_q, mdata_q, hit_tot_q, miss_tot_q;

  logic             line_hit;
  logic [TAG_W-1:0] rd_tag;

  assign status_o.clear_last = (clr_idx_q == {INDEX_BITS{1'b1}});
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  // Line memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lines_mem[wr_idx] <= wr_entry;
    end
    if (cmd_i.accept) begin
      rd_entry_q <= lines_mem[address_i[TAG_LSB-1:OFFSET_W]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_idx_q <= clr_idx_q + INDEX_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= mode_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      fdata_q <= fill_data_i;
    end
  end

  assign rd_tag   = rd_entry_q[ENTRY_W-2 -: TAG_W];
  assign line_hit = rd_entry_q[ENTRY_W-1] && (rd_tag == addr_q[31:TAG_LSB]);

  always_comb begin
    pending_d   = pending_q;
    pend_addr_d = pend_addr_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    rvalid_d    = 1'b0;
    rdata_d     = '0;
    hit_d       = 1'b0;
    freq_d      = 1'b0;
    raddr_d     = '0;
    mwrite_d    = 1'b0;
    mdata_d     = '0;
    perr_d      = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = clr_idx_q;
    wr_entry    = '0;

    if (cmd_i.clear_en) begin
      wr_en = 1'b1;
    end

    if (mode_q == MODE_READ && !pending_q) begin
      if (line_hit) begin
        hit_cnt_d = hit_cnt_q + 32'd1;
        rvalid_d  = 1'b1;
        rdata_d   = rd_entry_q[WORD_W-1:0];
        hit_d     = 1'b1;
      end else begin
        miss_cnt_d  = miss_cnt_q + 32'd1;
        freq_d      = 1'b1;
        raddr_d     = addr_q;
        pending_d   = 1'b1;
        pend_addr_d = addr_q;
      end
    end else if (mode_q == MODE_WRITE && !pending_q) begin
      // Take the write port only on commit so the clearing pass is never overridden.
      if (cmd_i.commit) begin
        wr_en    = 1'b1;
        wr_idx   = addr_q[TAG_LSB-1:OFFSET_W];
        wr_entry = {1'b1, addr_q[31:TAG_LSB], wdata_q};
      end
      mwrite_d = 1'b1;
      raddr_d  = addr_q;
      mdata_d  = wdata_q;
    end else if (mode_q == MODE_FILL && pending_q) begin
      if (cmd_i.commit) begin
        wr_en    = 1'b1;
        wr_idx   = pend_addr_q[TAG_LSB-1:OFFSET_W];
        wr_entry = {1'b1, pend_addr_q[31:TAG_LSB], fdata_q};
      end
      pending_d = 1'b0;
      rvalid_d  = 1'b1;
      rdata_d   = fdata_q;
    end else begin
      perr_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      pend_addr_q <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      pending_q   <= pending_d;
      pend_addr_q <= pend_addr_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rvalid_q   <= rvalid_d;
      rdata_q    <= rdata_d;
      hit_q      <= hit_d;
      freq_q     <= freq_d;
      raddr_q    <= raddr_d;
      mwrite_q   <= mwrite_d;
      mdata_q    <= mdata_d;
      hit_tot_q  <= hit_cnt_d;
      miss_tot_q <= miss_cnt_d;
      perr_q     <= perr_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_valid_o        = rvalid_q;
  assign read_data_o         = rdata_q;
  assign hit_o               = hit_q;
  assign fill_request_o      = freq_q;
  assign request_address_o   = raddr_q;
  assign memory_write_o      = mwrite_q;
  assign memory_write_data_o = mdata_q;
  assign hit_total_o         = hit_tot_q;
  assign miss_total_o        = miss_tot_q;
  assign protocol_error_o    = perr_q;

endmodule

`default_nettype wire

// ===== design/direct_mapped_write_through_cache_unit.sv =====
// Path: an accepted word's line is read into the line memory's registered port, then the
//   access is resolved into the result register once that register is free. The block
//   takes no new word until it has resolved the last one. A result still waiting holds off the next word.
// Reset: asynchronous, active low. Afterwards a clearing pass invalidates every line,
//   all 2**INDEX_BITS of them (64 at the default), with in_stall_o high throughout.
`default_nettype none

module direct_mapped_write_through_cache_unit import dmwtc_pkg::*; #(
  parameter int unsigned INDEX_BITS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Access channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [31:0] fill_data_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             read_valid_o,
  output logic [31:0]      read_data_o,
  output logic             hit_o,
  output logic             fill_request_o,
  output logic [31:0]      request_address_o,
  output logic             memory_write_o,
  output logic [31:0]      memory_write_data_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o,
  output logic             protocol_error_o
);

  // The controller sequences clear sweep, accept and commit. The datapath holds the
  // line memory ({valid, tag, word} per line), the pending-miss state, the hit and
  // miss counters and the output register that decouples the two channels.
  dmwtc_cmd_t    cmd;
  dmwtc_status_t status;

  dmwtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmwtc_dpath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .mode_i              (mode_i),
    .address_i           (address_i),
    .write_data_i        (write_data_i),
    .fill_data_i         (fill_data_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .read_valid_o        (read_valid_o),
    .read_data_o         (read_data_o),
    .hit_o               (hit_o),
    .fill_request_o      (fill_request_o),
    .request_address_o   (request_address_o),
    .memory_write_o      (memory_write_o),
    .memory_write_data_o (memory_write_data_o),
    .hit_total_o         (hit_total_o),
    .miss_total_o        (miss_total_o),
    .protocol_error_o    (protocol_error_o)
  );

endmodule

`default_nettype wire

// ===== tb/direct_mapped_write_through_cache_unit_tb.sv =====
`default_nettype none

module direct_mapped_write_through_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmwtc_pkg::*;

  // Geometry of the cache under test: 64 lines of one word each.
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned LINES   = 1 << INDEX_W;
  localparam int unsigned TAG_W   = WORD_W - INDEX_W - OFFSET_W;

  // The selector value the block does not define; it must be flagged and dropped.
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  // Bound the run: ~700 words, each with its block time, sender gap and receiver stall,
  // plus the clearing pass and the long receiver hold. Taken many times over.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned WORDS_PER_PHASE = 227;

  // One result word of the block, field by field.
  typedef struct packed {
    logic        read_valid;
    logic [31:0] read_data;
    logic        hit;
    logic        fill_request;
    logic [31:0] request_address;
    logic        memory_write;
    logic [31:0] memory_write_data;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic        protocol_error;
  } cache_resp_t;

  // Shadow copy of the cache: mirrors lines, counters and the open miss, predicts the
  // response to every accepted access and checks the responses in order.
  class cache_shadow;
    logic [TAG_W-1:0] tag_mem [LINES];
    bit               line_live [LINES];
    logic [31:0]      word_mem [LINES];
    logic [31:0]      hit_cnt;
    logic [31:0]      miss_cnt;
    bit               miss_open;
    logic [31:0]      miss_addr;
    cache_resp_t      awaited[$];
    int unsigned      mismatches;
    int unsigned      hits_seen, misses_seen, fills_seen, writes_seen, flagged_seen;

    function new();
      hit_cnt = '0;
      miss_cnt = '0;
      miss_open = 1'b0;
      miss_addr = '0;
      mismatches = 0;
      hits_seen = 0;
      misses_seen = 0;
      fills_seen = 0;
      writes_seen = 0;
      flagged_seen = 0;
      foreach (line_live[i]) line_live[i] = 1'b0;
    endfunction

    function void install(logic [31:0] addr, logic [31:0] data);
      logic [INDEX_W-1:0] idx;
      idx = addr[INDEX_W+OFFSET_W-1:OFFSET_W];
      tag_mem[idx] = addr[31:INDEX_W+OFFSET_W];
      line_live[idx] = 1'b1;
      word_mem[idx] = data;
    endfunction

    // Predict the response to one accepted access; return 1 when it is flagged.
    function bit note_access(logic [1:0] mode, logic [31:0] addr, logic [31:0] wdata,
                             logic [31:0] fdata);
      cache_resp_t        r;
      logic [INDEX_W-1:0] idx;
      r = '0;
      idx = addr[INDEX_W+OFFSET_W-1:OFFSET_W];
      if (mode == MODE_READ && !miss_open) begin
        if (line_live[idx] && tag_mem[idx] == addr[31:INDEX_W+OFFSET_W]) begin
          hit_cnt++;
          r.read_valid = 1'b1;
          r.read_data = word_mem[idx];
          r.hit = 1'b1;
          hits_seen++;
        end else begin
          miss_cnt++;
          r.fill_request = 1'b1;
          r.request_address = addr;
          miss_open = 1'b1;
          miss_addr = addr;
          misses_seen++;
        end
      end else if (mode == MODE_WRITE && !miss_open) begin
        install(addr, wdata);
        r.memory_write = 1'b1;
        r.request_address = addr;
        r.memory_write_data = wdata;
        writes_seen++;
      end else if (mode == MODE_FILL && miss_open) begin
        install(miss_addr, fdata);
        miss_open = 1'b0;
        r.read_valid = 1'b1;
        r.read_data = fdata;
        fills_seen++;
      end else begin
        r.protocol_error = 1'b1;
        flagged_seen++;
      end
      r.hit_total = hit_cnt;
      r.miss_total = miss_cnt;
      awaited.push_back(r);
      return r.protocol_error;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(cache_resp_t got);
      cache_resp_t want;
      if (awaited.size() == 0) begin
        $display("%0t: response with nothing awaited, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("fill_request", 32'(want.fill_request), 32'(got.fill_request));
      compare_field("request_address", want.request_address, got.request_address);
      compare_field("memory_write", 32'(want.memory_write), 32'(got.memory_write));
      compare_field("memory_write_data", want.memory_write_data, got.memory_write_data);
      compare_field("hit_total", want.hit_total, got.hit_total);
      compare_field("miss_total", want.miss_total, got.miss_total);
      compare_field("protocol_error", 32'(want.protocol_error), 32'(got.protocol_error));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [31:0] address_i;
  logic [31:0] write_data_i;
  logic [31:0] fill_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        read_valid_o;
  logic [31:0] read_data_o;
  logic        hit_o;
  logic        fill_request_o;
  logic [31:0] request_address_o;
  logic        memory_write_o;
  logic [31:0] memory_write_data_o;
  logic [31:0] hit_total_o;
  logic [31:0] miss_total_o;
  logic        protocol_error_o;

  cache_shadow shadow;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_left;
  int unsigned cycle_count;
  int unsigned words_sent;
  bit          last_flagged;

  direct_mapped_write_through_cache_unit #(
    .INDEX_BITS(INDEX_W)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .address_i          (address_i),
    .write_data_i       (write_data_i),
    .fill_data_i        (fill_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_valid_o       (read_valid_o),
    .read_data_o        (read_data_o),
    .hit_o              (hit_o),
    .fill_request_o     (fill_request_o),
    .request_address_o  (request_address_o),
    .memory_write_o     (memory_write_o),
    .memory_write_data_o(memory_write_data_o),
    .hit_total_o        (hit_total_o),
    .miss_total_o       (miss_total_o),
    .protocol_error_o   (protocol_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: end the run as failed if the drain never completes.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d responses still awaited", $time,
             cycle_count, shadow.awaited.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: take a word at every edge where valid is high and stall is low, then
  // pick the stall for the next cycle. A long hold, once requested, overrides the dice.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        shadow.check_response('{read_valid_o, read_data_o, hit_o, fill_request_o,
                                request_address_o, memory_write_o, memory_write_data_o,
                                hit_total_o, miss_total_o, protocol_error_o});
      end
      if (rx_hold_left > 0) begin
        out_stall_i <= 1'b1;
        rx_hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Offer one word, after a random gap, and hold it until the block takes it.
  // Note it in the shadow at the accepting edge so the next choice sees the new state.
  task automatic send_access(logic [1:0] mode, logic [31:0] addr, logic [31:0] wdata,
                             logic [31:0] fdata);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    address_i    <= addr;
    write_data_i <= wdata;
    fill_data_i  <= fdata;
    do @(posedge clk_i); while (in_stall_o);
    last_flagged = shadow.note_access(mode, addr, wdata, fdata);
    words_sent++;
  endtask

  // Draw addresses mostly from a few fixed tags so reads find their lines again;
  // keep most accesses word aligned.
  function automatic logic [31:0] pick_address();
    logic [TAG_W-1:0]    tg;
    logic [INDEX_W-1:0]  idx;
    logic [OFFSET_W-1:0] off;
    case ($urandom_range(3))
      0:       tg = '0;
      1:       tg = '1;
      2:       tg = 24'hA5C396;
      default: tg = TAG_W'($urandom);
    endcase
    idx = INDEX_W'($urandom);
    off = ($urandom_range(7) == 0) ? OFFSET_W'($urandom) : '0;
    return {tg, idx, off};
  endfunction

  // Mostly well-formed traffic: answer an open miss with its fill, otherwise read or
  // write. Mix in stray fills, accesses during a miss and the undefined selector.
  task automatic random_access();
    int unsigned dice;
    logic [1:0]  mode;
    dice = $urandom_range(99);
    if (shadow.miss_open) begin
      if (dice < 80)      mode = MODE_FILL;
      else if (dice < 88) mode = MODE_READ;
      else if (dice < 95) mode = MODE_WRITE;
      else                mode = MODE_UNDEF;
    end else begin
      if (dice < 50)      mode = MODE_READ;
      else if (dice < 85) mode = MODE_WRITE;
      else if (dice < 93) mode = MODE_FILL;
      else                mode = MODE_UNDEF;
    end
    send_access(mode, pick_address(), $urandom, $urandom);
  endtask

  initial begin
    int unsigned useful;
    shadow = new();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 0;
    words_sent   = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_READ;
    address_i    <= '0;
    write_data_i <= '0;
    fill_data_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cold miss, every flagged case, fills at both data extremes, eviction,
    // unaligned reads and writes, extreme addresses.
    send_access(MODE_READ,  32'h0000_0000, 32'h0,         32'h0);
    send_access(MODE_WRITE, 32'h0000_0100, 32'hDEAD_BEEF, 32'h0);
    send_access(MODE_READ,  32'h0000_0004, 32'h0,         32'h0);
    send_access(MODE_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(MODE_FILL,  32'hFFFF_FFFF, 32'h0,         32'hFFFF_FFFF);
    send_access(MODE_READ,  32'h0000_0000, 32'h0,         32'h0);
    send_access(MODE_READ,  32'h0000_0003, 32'h0,         32'h0);
    send_access(MODE_FILL,  32'h0000_0000, 32'h0,         32'h1111_1111);
    send_access(MODE_UNDEF, 32'h0000_0000, 32'h0,         32'h0);
    send_access(MODE_WRITE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0);
    send_access(MODE_READ,  32'hFFFF_FFFC, 32'h0,         32'h0);
    send_access(MODE_READ,  32'h0000_00FC, 32'h0,         32'h0);
    send_access(MODE_FILL,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(MODE_READ,  32'hFFFF_FFFF, 32'h0,         32'h0);
    send_access(MODE_FILL,  32'h0000_0000, 32'h0,         32'h1234_5678);
    send_access(MODE_WRITE, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(MODE_READ,  32'h0000_0000, 32'h0,         32'h0);
    send_access(MODE_READ,  32'hFFFF_FF02, 32'h0,         32'h0);
    send_access(MODE_FILL,  32'h0000_0000, 32'h0,         32'h5A5A_5A5A);
    send_access(MODE_WRITE, 32'hAAAA_AAA8, 32'h5555_5555, 32'h0);
    send_access(MODE_READ,  32'hAAAA_AAA8, 32'h0,         32'h0);
    send_access(MODE_WRITE, 32'h5555_5554, 32'hAAAA_AAAA, 32'h0);
    send_access(MODE_READ,  32'h5555_5557, 32'h0,         32'h0);

    // Random: sender dense / receiver busy, then swapped, then both at full rate with
    // one long receiver hold up front so the block fills and stalls its input.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          rx_hold_left = LONG_HOLD;
        end
      endcase
      useful = 0;
      while (useful < WORDS_PER_PHASE) begin
        random_access();
        if (!last_flagged) useful++;
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every awaited response, then keep watching for strays.
    while (shadow.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d words: %0d read hits, %0d read misses, %0d fills, %0d writes,",
             words_sent, shadow.hits_seen, shadow.misses_seen, shadow.fills_seen,
             shadow.writes_seen);
    $display("%0d flagged protocol breaks, with sender and receiver stalls in both mixes.",
             shadow.flagged_seen);
    if (shadow.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/dmwtc_pkg.sv
design/dmwtc_ctrl.sv
design/dmwtc_dpath.sv
design/direct_mapped_write_through_cache_unit.sv
tb/direct_mapped_write_through_cache_unit_tb.sv
